[design/rmic_pkg.sv]
// Shared constants for the row-major index converter.
// Field widths, register indexes and status codes; no dependencies.
package rmic_pkg;

  localparam int FLAT_W      = 60;  // flat index width
  localparam int COORD_W     = 10;  // coordinate and size field width
  localparam int NDIM_FIELDS = 6;   // coordinate fields on the ports
  localparam int STEP_BITS   = 4;   // quotient bits retired per stage
  localparam int CFG_ADDR_W  = 5;
  localparam int NDIMS_W     = 3;

  localparam int MAX_DIMS_DEF = 6;
  localparam int DIM_BITS_DEF = 10;

  localparam logic [2:0] REG_NUM_DIMS = 3'd0;
  localparam logic [2:0] REG_SIZE_LO  = 3'd1;
  localparam logic [2:0] REG_SIZE_HI  = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IDX_RANGE = 2'd1;
  localparam logic [1:0] ST_COORD_BAD = 2'd2;

endpackage

[design/row_major_index_convert.sv]
// Row-major ravel/unravel converter with an APB-style register port.
// Uses rmic_pkg for widths, register indexes and status codes.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+---------------------------------
//   input    | in_valid / in_ready            | in_mode, in_flat_index, in_coord_in_*
//   result   | out_valid / out_ready          | out_flat_index_out, out_coord_out_*,
//            |                                | out_status
//   config   | cfg_psel/penable/pwrite/pready | cfg_paddr, cfg_pwdata, cfg_prdata
//
// One item per cycle is accepted while the output register is empty or its result is taken;
// each result passes through the restoring divider chain, which retires four quotient bits
// of the 60-bit index per stage for each of six dimensions, and then the result register,
// which is loaded from the last divider stage.
// Reset (synchronous, rst_n low) clears all valid bits and sets every configuration register to one.
// When the result is not taken the whole pipeline holds, so nothing is lost or repeated.
module row_major_index_convert #(
  parameter int MAX_DIMS = rmic_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS = rmic_pkg::DIM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [rmic_pkg::FLAT_W-1:0]   in_flat_index,
  input  logic [rmic_pkg::COORD_W-1:0]  in_coord_in_0,
  input  logic [rmic_pkg::COORD_W-1:0]  in_coord_in_1,
  input  logic [rmic_pkg::COORD_W-1:0]  in_coord_in_2,
  input  logic [rmic_pkg::COORD_W-1:0]  in_coord_in_3,
  input  logic [rmic_pkg::COORD_W-1:0]  in_coord_in_4,
  input  logic [rmic_pkg::COORD_W-1:0]  in_coord_in_5,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rmic_pkg::FLAT_W-1:0]   out_flat_index_out,
  output logic [rmic_pkg::COORD_W-1:0]  out_coord_out_0,
  output logic [rmic_pkg::COORD_W-1:0]  out_coord_out_1,
  output logic [rmic_pkg::COORD_W-1:0]  out_coord_out_2,
  output logic [rmic_pkg::COORD_W-1:0]  out_coord_out_3,
  output logic [rmic_pkg::COORD_W-1:0]  out_coord_out_4,
  output logic [rmic_pkg::COORD_W-1:0]  out_coord_out_5,
  output logic [1:0]                    out_status,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rmic_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import rmic_pkg::*;

  localparam int STEPS = FLAT_W / STEP_BITS;
  localparam int NSTG  = NDIM_FIELDS * STEPS;
  localparam int DB    = DIM_BITS;
  localparam logic [COORD_W-1:0] DMASK = COORD_W'((1 << DIM_BITS) - 1);
  localparam logic [NDIMS_W-1:0] MAXD  = NDIMS_W'(MAX_DIMS);

  typedef struct packed {
    logic                                 valid;
    logic                                 mode;
    logic [FLAT_W-1:0]                    w;      // dividend bits, then quotient
    logic [DB-1:0]                        r;      // partial remainder
    logic [NDIM_FIELDS-1:0][COORD_W-1:0]  coord;
    logic [FLAT_W-1:0]                    acc;    // Horner sum for ravel
    logic                                 bad;
  } stage_t;

  // Configuration registers
  logic [NDIMS_W-1:0]                   num_dims_r;
  logic [NDIM_FIELDS-1:0][COORD_W-1:0]  dim_size_r;
  logic [2:0]                           cfg_idx;
  logic                                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= NDIMS_W'(1);
      for (int i = 0; i < NDIM_FIELDS; i++) begin
        dim_size_r[i] <= COORD_W'(1);
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_NUM_DIMS) begin
        num_dims_r <= cfg_pwdata[NDIMS_W-1:0];
      end else if (cfg_idx >= REG_SIZE_LO && cfg_idx <= REG_SIZE_HI) begin
        dim_size_r[cfg_idx - REG_SIZE_LO] <= cfg_pwdata[COORD_W-1:0] & DMASK;
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx == REG_NUM_DIMS) begin
      cfg_prdata = 32'(num_dims_r);
    end else if (cfg_idx >= REG_SIZE_LO && cfg_idx <= REG_SIZE_HI) begin
      cfg_prdata = 32'(dim_size_r[cfg_idx - REG_SIZE_LO]);
    end
  end

  // Dimensions in use, clamped to the supported range.
  logic [NDIMS_W-1:0] n_use;
  always_comb begin
    if (num_dims_r == '0) begin
      n_use = NDIMS_W'(1);
    end else if (num_dims_r > MAXD) begin
      n_use = MAXD;
    end else begin
      n_use = num_dims_r;
    end
  end

  logic   en;
  logic   out_valid_r;
  stage_t in_rec;
  stage_t src   [NSTG];
  stage_t stg_r [NSTG];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    in_rec       = '0;
    in_rec.valid = in_valid;
    in_rec.mode  = in_mode;
    in_rec.w     = in_flat_index;
    if (in_mode) begin
      in_rec.coord[0] = in_coord_in_0;
      in_rec.coord[1] = in_coord_in_1;
      in_rec.coord[2] = in_coord_in_2;
      in_rec.coord[3] = in_coord_in_3;
      in_rec.coord[4] = in_coord_in_4;
      in_rec.coord[5] = in_coord_in_5;
    end
  end

  assign src[0] = in_rec;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int  D     = NDIM_FIELDS - 1 - s / STEPS;
    localparam bit  FIRST = (s % STEPS) == 0;
    localparam bit  LAST  = (s % STEPS) == STEPS - 1;
    stage_t nxt;

    if (s > 0) begin : g_link
      assign src[s] = stg_r[s-1];
    end

    // Each stage retires STEP_BITS quotient bits for dimension D; dimensions
    // beyond the count in use divide by one so the index passes through.
    always_comb begin
      logic [DB-1:0]            dv;
      logic [DB:0]              rr;
      logic                     ge;
      logic [COORD_W-1:0]       c;
      logic [COORD_W-1:0]       sz;
      logic [FLAT_W+COORD_W-1:0] prod;
      nxt = src[s];
      dv  = (NDIMS_W'(D) < n_use) ? dim_size_r[D][DB-1:0] : DB'(1);
      if (FIRST) begin
        nxt.r = '0;
      end
      for (int k = 0; k < STEP_BITS; k++) begin
        rr    = {nxt.r, nxt.w[FLAT_W-1]};
        ge    = rr >= {1'b0, dv};
        nxt.w = {nxt.w[FLAT_W-2:0], ge};
        rr    = ge ? (rr - {1'b0, dv}) : rr;
        nxt.r = rr[DB-1:0];
      end
      if (LAST && !nxt.mode) begin
        nxt.coord[D] = COORD_W'(nxt.r);
      end
      c    = '0;
      sz   = '0;
      prod = '0;
      if (s < NDIM_FIELDS) begin
        if (NDIMS_W'(s) < n_use) begin
          c    = src[s].coord[s % NDIM_FIELDS] & DMASK;
          sz   = dim_size_r[s % NDIM_FIELDS] & DMASK;
          prod = src[s].acc * sz;
          nxt.acc = prod[FLAT_W-1:0] + FLAT_W'(c);
          if (sz == '0 || c >= sz) begin
            nxt.bad = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[s].valid <= 1'b0;
      end else if (en) begin
        stg_r[s] <= nxt;
      end
    end
  end

  // Final stage: range check and result formatting.
  stage_t lst;
  logic   zero_any;
  assign lst = stg_r[NSTG-1];

  always_comb begin
    zero_any = 1'b0;
    for (int i = 0; i < NDIM_FIELDS; i++) begin
      if (NDIMS_W'(i) < n_use && (dim_size_r[i] & DMASK) == '0) begin
        zero_any = 1'b1;
      end
    end
  end

  logic [FLAT_W-1:0]                    flat_r;
  logic [NDIM_FIELDS-1:0][COORD_W-1:0]  coord_r;
  logic [1:0]                           status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lst.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flat_r   <= '0;
      coord_r  <= '0;
      status_r <= ST_OK;
      if (!lst.mode) begin
        // A nonzero final quotient means the index reached the element count.
        if (lst.w != '0 || zero_any) begin
          status_r <= ST_IDX_RANGE;
        end else begin
          coord_r <= lst.coord;
        end
      end else if (n_use == NDIMS_W'(1)) begin
        flat_r <= FLAT_W'(lst.coord[0] & DMASK);
      end else if (lst.bad) begin
        status_r <= ST_COORD_BAD;
      end else begin
        flat_r <= lst.acc;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_flat_index_out = flat_r;
  assign out_coord_out_0    = coord_r[0];
  assign out_coord_out_1    = coord_r[1];
  assign out_coord_out_2    = coord_r[2];
  assign out_coord_out_3    = coord_r[3];
  assign out_coord_out_4    = coord_r[4];
  assign out_coord_out_5    = coord_r[5];
  assign out_status         = status_r;

endmodule

[bench/rmic_checker.sv]
// Result checker for the row-major index converter: predicts each result
// from the accepted items and the register shadow. Depends on rmic_pkg.
`timescale 1ns / 1ps
module rmic_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_mode,
  input  logic [59:0] in_flat_index,
  input  logic [9:0]  in_coord [6],
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [59:0] out_flat_index_out,
  input  logic [9:0]  out_coord [6],
  input  logic [1:0]  out_status,
  input  logic [2:0]  shadow_num_dims,
  input  logic [9:0]  shadow_size [6],
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import rmic_pkg::*;

  typedef struct packed {
    logic [59:0]    flat;
    logic [5:0][9:0] coord;
    logic [1:0]     status;
  } conversion_t;

  conversion_t expected_q[$];

  function automatic conversion_t convert(input logic mode, input logic [59:0] flat,
                                          input logic [9:0] coord [6]);
    conversion_t r;
    int n;
    logic [63:0] total, rem, acc;
    bit bad;
    r = '0;
    n = int'(shadow_num_dims);
    if (n < 1) n = 1;
    if (n > 6) n = 6;
    if (!mode) begin
      total = 64'd1;
      for (int i = 0; i < n; i++) total = total * {54'b0, shadow_size[i]};
      if ({4'b0, flat} >= total) begin
        r.status = ST_IDX_RANGE;
      end else begin
        rem = {4'b0, flat};
        for (int i = n - 1; i >= 0; i--) begin
          r.coord[i] = 10'(rem % {54'b0, shadow_size[i]});
          rem = rem / {54'b0, shadow_size[i]};
        end
      end
    end else if (n == 1) begin
      r.flat = 60'(coord[0]);
    end else begin
      bad = 0;
      acc = 64'd0;
      for (int i = 0; i < n; i++)
        if (shadow_size[i] == 0 || coord[i] >= shadow_size[i]) bad = 1;
      if (bad) begin
        r.status = ST_COORD_BAD;
      end else begin
        for (int i = 0; i < n; i++)
          acc = acc * {54'b0, shadow_size[i]} + {54'b0, coord[i]};
        r.flat = acc[59:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    conversion_t got, want;
    if (!rst_n) begin
      fail_count    <= 0;
      result_count  <= 0;
      expected_q.delete();
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(), convert(in_mode, in_flat_index, in_coord));
      if (out_valid && out_ready) begin
        got.flat   = out_flat_index_out;
        for (int i = 0; i < 6; i++) got.coord[i] = out_coord[i];
        got.status = out_status;
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.flat !== want.flat || got.coord !== want.coord
              || got.status !== want.status) begin
            $display("%0t: mismatch expected flat=%h coord=%h status=%0d", $time,
                     want.flat, want.coord, want.status);
            $display("%0t:          actual   flat=%h coord=%h status=%0d", $time,
                     got.flat, got.coord, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_q.size();
    end
  end
endmodule

[bench/tb_row_major_index_convert.sv]
// Testbench top for row_major_index_convert: drives items and register
// writes, and gives the verdict. Depends on rmic_pkg and rmic_checker.
`timescale 1ns / 1ps
module tb_row_major_index_convert;
  import rmic_pkg::*;

  localparam int LATENCY   = 91;
  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_mode;
  logic [59:0] in_flat_index;
  logic [9:0]  in_coord [6];
  logic        out_valid, out_ready;
  logic [59:0] out_flat_index_out;
  logic [9:0]  out_coord [6];
  logic [1:0]  out_status;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic [2:0]  shadow_num_dims;
  logic [9:0]  shadow_size [6];
  int fail_count, pending_count, result_count;
  int idle_cycles;
  int accepted;

  row_major_index_convert u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_flat_index,
    .in_coord_in_0(in_coord[0]), .in_coord_in_1(in_coord[1]),
    .in_coord_in_2(in_coord[2]), .in_coord_in_3(in_coord[3]),
    .in_coord_in_4(in_coord[4]), .in_coord_in_5(in_coord[5]),
    .out_valid, .out_ready, .out_flat_index_out,
    .out_coord_out_0(out_coord[0]), .out_coord_out_1(out_coord[1]),
    .out_coord_out_2(out_coord[2]), .out_coord_out_3(out_coord[3]),
    .out_coord_out_4(out_coord[4]), .out_coord_out_5(out_coord[5]),
    .out_status, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  rmic_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls: random, with stretches of steady readiness.
  int ready_mode = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) ready_mode = $urandom_range(0, 2);
      if (ready_mode == 0) out_ready <= 1'b1;
      else if (ready_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 9) == 0) ? 1'b1 : (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(input int index, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 5'(4 * index); cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (index == REG_NUM_DIMS) shadow_num_dims = value[2:0];
    else shadow_size[index - 1] = value[9:0];
  endtask

  // Called at a falling edge; the last item's valid is dropped here.
  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Valid stays high into the next item when there is no gap, so items can
  // follow back to back.
  task automatic send_item(input logic mode, input logic [59:0] flat,
                           input logic [9:0] c [6]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1; in_mode <= mode; in_flat_index <= flat;
    for (int i = 0; i < 6; i++) in_coord[i] <= c[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted++;
    @(negedge clk);
  endtask

  function automatic logic [59:0] rand_flat();
    return 60'({$urandom, $urandom} >> $urandom_range(0, 63));
  endfunction

  // Mostly well-formed items: in-range indexes and coordinates, some outside.
  task automatic random_item();
    logic [9:0] c [6];
    logic [63:0] total;
    logic [59:0] f;
    int n;
    n = shadow_num_dims == 0 ? 1 : (shadow_num_dims > 6 ? 6 : int'(shadow_num_dims));
    total = 64'd1;
    for (int i = 0; i < n; i++) total = total * {54'b0, shadow_size[i]};
    for (int i = 0; i < 6; i++) begin
      if (shadow_size[i] != 0 && $urandom_range(0, 9) != 0)
        c[i] = 10'($urandom_range(0, shadow_size[i] - 1));
      else
        c[i] = 10'($urandom);
    end
    if (total != 0 && $urandom_range(0, 9) != 0) f = 60'({4'b0, rand_flat()} % total);
    else f = rand_flat();
    if ($urandom_range(0, 19) == 0) f = total[59:0];
    send_item(1'($urandom_range(0, 1)), f, c);
  endtask

  task automatic set_shape(input int n, input int s0, input int s1, input int s2,
                           input int s3, input int s4, input int s5);
    reg_write(REG_NUM_DIMS, n);
    reg_write(1, s0); reg_write(2, s1); reg_write(3, s2);
    reg_write(4, s3); reg_write(5, s4); reg_write(6, s5);
  endtask

  initial begin
    logic [9:0] c [6];
    logic [9:0] zc [6];
    accepted = 0;
    rst_n = 0;
    in_valid = 0; in_mode = 0; in_flat_index = 0;
    for (int i = 0; i < 6; i++) begin
      in_coord[i] = 0; zc[i] = 0; shadow_size[i] = 1;
    end
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    shadow_num_dims = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset shape, extremes of each field.
    send_item(0, 0, zc);
    send_item(0, 1, zc);
    for (int i = 0; i < 6; i++) c[i] = 10'h3ff;
    send_item(1, 60'hfff_ffff_ffff_ffff, c);
    send_item(0, 60'hfff_ffff_ffff_ffff, c);
    drain();
    set_shape(6, 1023, 1023, 1023, 1023, 1023, 1023);
    send_item(0, 60'hfff_ffff_ffff_ffff, zc);
    send_item(0, 60'd1023 ** 6 - 1, zc);
    send_item(0, 60'd1023 ** 6, zc);
    for (int i = 0; i < 6; i++) c[i] = 10'd1022;
    send_item(1, 0, c);
    c[3] = 10'd1023;
    send_item(1, 0, c);
    drain();
    // Zero size in use, then counts of zero and seven.
    set_shape(3, 5, 0, 7, 1, 1, 1);
    send_item(0, 0, zc);
    send_item(1, 0, zc);
    drain();
    set_shape(0, 17, 2, 3, 4, 5, 6);
    send_item(0, 16, zc);
    send_item(0, 17, zc);
    c[0] = 10'd900;
    send_item(1, 0, c);
    drain();
    set_shape(7, 2, 3, 4, 5, 6, 7);
    send_item(0, 5039, zc);
    send_item(0, 5040, zc);
    for (int i = 0; i < 6; i++) c[i] = 10'(i + 1);
    send_item(1, 0, c);
    drain();

    // Random phases over assorted shapes; sender waits for a full drain between.
    for (int phase = 0; phase < 10; phase++) begin
      int n;
      n = $urandom_range(0, 7);
      reg_write(REG_NUM_DIMS, n);
      for (int i = 1; i <= 6; i++)
        reg_write(i, ($urandom_range(0, 15) == 0) ? 0 :
                     ($urandom_range(0, 3) == 0 ? $urandom_range(1, 1023)
                                                : $urandom_range(1, 12)));
      repeat (80) random_item();
      drain();
    end

    drain();
    $display("Covered %0d items, %0d results, over directed and random shapes", accepted,
             result_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

[filelist.f]
design/rmic_pkg.sv
design/row_major_index_convert.sv
bench/rmic_checker.sv
bench/tb_row_major_index_convert.sv
